FILE: rtl/sparse_series_interpolator_core_defines.svh
// ---------------------------------------------------------------------------
// sparse series interpolator assertion macros
// shared property forms for the port checker
// ---------------------------------------------------------------------------
`ifndef SPARSE_SERIES_INTERPOLATOR_CORE_DEFINES_SVH
`define SPARSE_SERIES_INTERPOLATOR_CORE_DEFINES_SVH

// same-cycle implication under synchronous active-low reset
`define SSI_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under synchronous active-low reset
`define SSI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/ssi_pkg.sv
// ---------------------------------------------------------------------------
// ssi_pkg
// types, constants and helpers of the sparse series interpolator
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ssi_pkg;

    // parameter defaults
    localparam int DEF_MAX_POINTS = 64;
    localparam int DEF_MAX_WRAPS  = 16;

    // field widths
    localparam int TIME_W  = 48;
    localparam int VALUE_W = 32;
    localparam int IDX_W   = 6;
    localparam int ACC_W   = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;
    localparam int S_TDATA_W  = 136;
    localparam int M_TDATA_W  = 32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_INTERP = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXTRAP = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_START  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_END    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STEP   = 3'd5;

    // mode codes
    localparam logic [1:0] MODE_HOLD     = 2'd0;
    localparam logic [1:0] MODE_LINEAR   = 2'd1;
    localparam logic [1:0] MODE_PERIODIC = 2'd2;

    // item kinds
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_HOLD,
        S_LDL,
        S_LDR,
        S_PREP,
        S_DIV,
        S_MUL,
        S_RES,
        S_FIN
    } t_state;

    typedef enum logic [2:0] {
        ACT_HOLD,
        ACT_LERP,
        ACT_FAIL,
        ACT_WRAP_UP,
        ACT_WRAP_DN
    } t_act;

    // sign extend a time to the working width
    function automatic logic signed [ACC_W-1:0] sext_time(input logic [TIME_W-1:0] v);
        sext_time = $signed({{(ACC_W-TIME_W){v[TIME_W-1]}}, v});
    endfunction

endpackage

FILE: rtl/sparse_series_interpolator_core.sv
// ---------------------------------------------------------------------------
// sparse series interpolator core
// breakpoint table with hold, linear and periodic lookup of a time
// ---------------------------------------------------------------------------
//  channel  | direction | handshake            | payload
//  s_axis   | in        | tvalid / tready      | tdata fields, tuser = func
//  m_axis   | out       | tvalid / tready      | tdata = result_value, tuser = valid
//  cfg      | in        | valid / ready        | index, data
//
//  a load is written while the block stays idle; a query scans a non-empty table once
//  and once more per periodic wrap, then holds a value or interpolates a linear segment
//  (32 division steps and 32 multiply steps on one shared shift-add unit)
//  the scan rate is set by the single read port of the breakpoint memory
//  reset clears control and configuration; the table stays undefined until loaded
//  a finished result waits in S_FIN until the output register is free; no items go in meanwhile
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sparse_series_interpolator_core #(
    parameter int MAX_POINTS = ssi_pkg::DEF_MAX_POINTS,
    parameter int MAX_WRAPS  = ssi_pkg::DEF_MAX_WRAPS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // point_index, point_time, point_value, query_time, zero pad
    input  logic [ssi_pkg::S_TDATA_W-1:0]    i_s_axis_tdata,
    // func
    input  logic [0:0]                       i_s_axis_tuser,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // result_value
    output logic [ssi_pkg::M_TDATA_W-1:0]    o_m_axis_tdata,
    // result_valid
    output logic [0:0]                       o_m_axis_tuser,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [ssi_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ssi_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int WW = $clog2(MAX_WRAPS + 1);
    localparam int TW = ssi_pkg::TIME_W;
    localparam int VW = ssi_pkg::VALUE_W;
    localparam int XW = ssi_pkg::ACC_W;

    // input fields
    logic [ssi_pkg::IDX_W-1:0] in_idx;
    logic [TW-1:0]             in_ptime;
    logic [VW-1:0]             in_pval;
    logic [TW-1:0]             in_qtime;
    assign in_idx   = i_s_axis_tdata[5:0];
    assign in_ptime = i_s_axis_tdata[53:6];
    assign in_pval  = i_s_axis_tdata[85:54];
    assign in_qtime = i_s_axis_tdata[133:86];

    // configuration registers
    logic [1:0]        r_interp, r_extrap;
    logic [6:0]        r_pcount;
    logic [TW-1:0]     r_sstart, r_send;
    logic [TW-2:0]     r_step;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interp <= ssi_pkg::MODE_LINEAR;
            r_extrap <= ssi_pkg::MODE_HOLD;
            r_pcount <= '0;
            r_sstart <= '0;
            r_send   <= '0;
            r_step   <= (TW-1)'(1);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ssi_pkg::REG_INTERP: r_interp <= i_cfg_data[1:0];
                ssi_pkg::REG_EXTRAP: r_extrap <= i_cfg_data[1:0];
                ssi_pkg::REG_COUNT:  r_pcount <= i_cfg_data[6:0];
                ssi_pkg::REG_START:  r_sstart <= i_cfg_data;
                ssi_pkg::REG_END:    r_send   <= i_cfg_data;
                ssi_pkg::REG_STEP:   r_step   <= i_cfg_data[TW-2:0];
                default: ;
            endcase
        end
    end

    // breakpoint memory, one write and one registered read port
    logic [TW-1:0] mem_t [MAX_POINTS];
    logic [VW-1:0] mem_v [MAX_POINTS];
    logic [TW-1:0] r_tdat;
    logic [VW-1:0] r_vdat;
    logic [AW-1:0] rd_addr;
    logic          in_acc, load_acc, query_acc, load_ok;

    assign in_acc    = i_s_axis_tvalid && o_s_axis_tready;
    assign load_acc  = in_acc && (i_s_axis_tuser[0] == ssi_pkg::FUNC_LOAD);
    assign query_acc = in_acc && (i_s_axis_tuser[0] == ssi_pkg::FUNC_QUERY);
    assign load_ok   = 32'(in_idx) < 32'(MAX_POINTS);

    always_ff @(posedge i_clk) begin
        if (load_acc && load_ok) begin
            mem_t[AW'(in_idx)] <= in_ptime;
            mem_v[AW'(in_idx)] <= in_pval;
        end
        r_tdat <= mem_t[rd_addr];
        r_vdat <= mem_v[rd_addr];
    end

    // sequencer state and working registers
    ssi_pkg::t_state r_state, n_state;
    ssi_pkg::t_act   act;
    logic signed [XW-1:0] r_t, r_period, r_endstep, r_tl, r_tr;
    logic [XW-1:0]   r_rem, r_den;
    logic [VW-1:0]   r_vl, r_vr, r_res;
    logic            r_ok, r_found, r_pv, r_is_last, r_neg;
    logic [CW-1:0]   r_n, r_idx;
    logic [AW-1:0]   r_pidx, r_left;
    logic [WW-1:0]   r_wraps;
    logic [31:0]     r_frac;
    logic [4:0]      r_cnt;
    logic [VW:0]     r_mag;
    logic [VW+1:0]   r_acc;
    logic            r_ovld;
    logic [VW-1:0]   r_odata;
    logic            r_ouser;

    logic [CW-1:0]   n_eff;
    logic            is_last, ge_end, wrap_ok, issue, out_free;
    logic [XW-1:0]   rem2;
    logic [VW:0]     diff;
    logic [VW+2:0]   msum;

    assign n_eff    = (32'(r_pcount) > 32'(MAX_POINTS)) ? CW'(MAX_POINTS) : CW'(r_pcount);
    assign is_last  = (CW'(r_left) + CW'(1)) == r_n;
    assign ge_end   = r_t >= r_endstep;
    assign wrap_ok  = r_wraps < WW'(MAX_WRAPS);
    assign issue    = r_idx < r_n;
    assign out_free = !r_ovld || i_m_axis_tready;
    assign rem2     = {r_rem[XW-2:0], 1'b0};
    assign diff     = {r_vr[VW-1], r_vr} - {r_vl[VW-1], r_vl};
    assign msum     = {1'b0, r_acc} + (r_frac[0] ? {2'b00, r_mag} : '0);

    assign o_s_axis_tready = (r_state == ssi_pkg::S_IDLE);
    assign o_m_axis_tvalid = r_ovld;
    assign o_m_axis_tdata  = r_odata;
    assign o_m_axis_tuser  = r_ouser;

    // decision after a scan
    always_comb begin
        if (!r_found) begin
            if (r_extrap == ssi_pkg::MODE_HOLD) act = ssi_pkg::ACT_HOLD;
            else if (r_extrap == ssi_pkg::MODE_PERIODIC && wrap_ok) act = ssi_pkg::ACT_WRAP_UP;
            else act = ssi_pkg::ACT_FAIL;
        end else if (!is_last) begin
            if (r_interp == ssi_pkg::MODE_HOLD) act = ssi_pkg::ACT_HOLD;
            else if (r_interp == ssi_pkg::MODE_LINEAR) act = ssi_pkg::ACT_LERP;
            else act = ssi_pkg::ACT_FAIL;
        end else if (r_extrap == ssi_pkg::MODE_HOLD) begin
            act = ssi_pkg::ACT_HOLD;
        end else if (r_extrap != ssi_pkg::MODE_PERIODIC) begin
            act = ssi_pkg::ACT_FAIL;
        end else if (ge_end) begin
            act = wrap_ok ? ssi_pkg::ACT_WRAP_DN : ssi_pkg::ACT_FAIL;
        end else if (r_interp == ssi_pkg::MODE_HOLD) begin
            act = ssi_pkg::ACT_HOLD;
        end else if (r_interp == ssi_pkg::MODE_LINEAR) begin
            act = ssi_pkg::ACT_LERP;
        end else begin
            act = ssi_pkg::ACT_FAIL;
        end
    end

    // next state and read address
    always_comb begin
        n_state = r_state;
        rd_addr = r_idx[AW-1:0];
        case (r_state)
            ssi_pkg::S_IDLE: begin
                if (query_acc) n_state = (n_eff == '0) ? ssi_pkg::S_FIN : ssi_pkg::S_SCAN;
            end
            ssi_pkg::S_SCAN: begin
                if (!issue && !r_pv) n_state = ssi_pkg::S_DECIDE;
            end
            ssi_pkg::S_DECIDE: begin
                rd_addr = r_found ? r_left : '0;
                case (act)
                    ssi_pkg::ACT_HOLD:    n_state = ssi_pkg::S_HOLD;
                    ssi_pkg::ACT_LERP:    n_state = ssi_pkg::S_LDL;
                    ssi_pkg::ACT_WRAP_UP: n_state = ssi_pkg::S_SCAN;
                    ssi_pkg::ACT_WRAP_DN: n_state = ssi_pkg::S_SCAN;
                    default:              n_state = ssi_pkg::S_FIN;
                endcase
            end
            ssi_pkg::S_HOLD: n_state = ssi_pkg::S_FIN;
            ssi_pkg::S_LDL: begin
                rd_addr = r_is_last ? '0 : AW'(r_left + AW'(1));
                n_state = ssi_pkg::S_LDR;
            end
            ssi_pkg::S_LDR:  n_state = ssi_pkg::S_PREP;
            ssi_pkg::S_PREP: n_state = ssi_pkg::S_DIV;
            ssi_pkg::S_DIV: begin
                if (r_cnt == 5'd31) n_state = ssi_pkg::S_MUL;
            end
            ssi_pkg::S_MUL: begin
                if (r_cnt == 5'd31) n_state = ssi_pkg::S_RES;
            end
            ssi_pkg::S_RES: n_state = ssi_pkg::S_FIN;
            ssi_pkg::S_FIN: begin
                if (out_free) n_state = ssi_pkg::S_IDLE;
            end
            default: n_state = ssi_pkg::S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ssi_pkg::S_IDLE;
        else r_state <= n_state;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld  <= 1'b0;
            r_pv    <= 1'b0;
            r_idx   <= '0;
            r_found <= 1'b0;
            r_wraps <= '0;
            r_cnt   <= '0;
        end else begin
            if (r_state == ssi_pkg::S_FIN && out_free) r_ovld <= 1'b1;
            else if (i_m_axis_tready) r_ovld <= 1'b0;
            case (r_state)
                ssi_pkg::S_IDLE: begin
                    r_idx   <= '0;
                    r_pv    <= 1'b0;
                    r_found <= 1'b0;
                    r_wraps <= '0;
                end
                ssi_pkg::S_SCAN: begin
                    if (issue) r_idx <= r_idx + CW'(1);
                    r_pv <= issue;
                    if (r_pv && (r_t >= ssi_pkg::sext_time(r_tdat))) r_found <= 1'b1;
                end
                ssi_pkg::S_DECIDE: begin
                    r_idx   <= '0;
                    r_pv    <= 1'b0;
                    r_found <= 1'b0;
                    r_cnt   <= '0;
                    if (act == ssi_pkg::ACT_WRAP_UP || act == ssi_pkg::ACT_WRAP_DN)
                        r_wraps <= r_wraps + WW'(1);
                end
                ssi_pkg::S_DIV, ssi_pkg::S_MUL: r_cnt <= r_cnt + 5'd1;
                default: ;
            endcase
        end
    end

    // shared shift-add datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            ssi_pkg::S_IDLE: begin
                r_t       <= ssi_pkg::sext_time(in_qtime);
                r_n       <= n_eff;
                r_period  <= ssi_pkg::sext_time(r_send) - ssi_pkg::sext_time(r_sstart)
                             + XW'(r_step);
                r_endstep <= ssi_pkg::sext_time(r_send) + XW'(r_step);
                r_res     <= '0;
                r_ok      <= 1'b0;
            end
            ssi_pkg::S_SCAN: begin
                r_pidx <= r_idx[AW-1:0];
                if (r_pv && (r_t >= ssi_pkg::sext_time(r_tdat))) r_left <= r_pidx;
            end
            ssi_pkg::S_DECIDE: begin
                r_is_last <= is_last;
                if (act == ssi_pkg::ACT_WRAP_UP) r_t <= r_t + r_period;
                if (act == ssi_pkg::ACT_WRAP_DN) r_t <= r_t - r_period;
                if (act == ssi_pkg::ACT_FAIL) begin
                    r_res <= '0;
                    r_ok  <= 1'b0;
                end
            end
            ssi_pkg::S_HOLD: begin
                r_res <= r_vdat;
                r_ok  <= 1'b1;
            end
            ssi_pkg::S_LDL: begin
                r_tl <= ssi_pkg::sext_time(r_tdat);
                r_vl <= r_vdat;
            end
            ssi_pkg::S_LDR: begin
                r_tr <= r_is_last ? r_endstep : ssi_pkg::sext_time(r_tdat);
                r_vr <= r_vdat;
            end
            ssi_pkg::S_PREP: begin
                r_rem  <= XW'(r_t - r_tl);
                r_den  <= XW'(r_tr - r_tl);
                r_frac <= '0;
                r_acc  <= '0;
                r_neg  <= diff[VW];
                r_mag  <= diff[VW] ? ((VW+1)'(0) - diff) : diff;
            end
            // restoring division, one quotient bit a step
            ssi_pkg::S_DIV: begin
                if (rem2 >= r_den) begin
                    r_rem  <= rem2 - r_den;
                    r_frac <= {r_frac[30:0], 1'b1};
                end else begin
                    r_rem  <= rem2;
                    r_frac <= {r_frac[30:0], 1'b0};
                end
            end
            // shift-add multiply, lowest fraction bit first
            ssi_pkg::S_MUL: begin
                r_acc  <= msum[VW+2:1];
                r_frac <= {1'b0, r_frac[31:1]};
            end
            ssi_pkg::S_RES: begin
                r_res <= r_neg ? (r_vl - r_acc[VW-1:0]) : (r_vl + r_acc[VW-1:0]);
                r_ok  <= 1'b1;
            end
            ssi_pkg::S_FIN: begin
                if (out_free) begin
                    r_odata <= r_res;
                    r_ouser <= r_ok;
                end
            end
            default: ;
        endcase
    end

endmodule

FILE: rtl/ssi_checker.sv
// ---------------------------------------------------------------------------
// ssi checker
// port-level checks of the sparse series interpolator
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sparse_series_interpolator_core_defines.svh"

module ssi_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_s_axis_tvalid,
    input logic                             o_s_axis_tready,
    input logic [ssi_pkg::S_TDATA_W-1:0]    i_s_axis_tdata,
    input logic [0:0]                       i_s_axis_tuser,
    input logic                             o_m_axis_tvalid,
    input logic                             i_m_axis_tready,
    input logic [ssi_pkg::M_TDATA_W-1:0]    o_m_axis_tdata,
    input logic [0:0]                       o_m_axis_tuser,
    input logic                             i_cfg_valid,
    input logic                             o_cfg_ready,
    input logic [ssi_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input logic [ssi_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    // a query occupies the block, a load does not
    `SSI_ASSERT_NEXT(a_query_busy, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tuser[0] == ssi_pkg::FUNC_QUERY, !o_s_axis_tready, "query item did not make the block busy")
    `SSI_ASSERT_NEXT(a_load_quick, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tuser[0] == ssi_pkg::FUNC_LOAD, o_s_axis_tready, "load item held the block")

    // no value is shown without a valid flag
    `SSI_ASSERT_NOW(a_nan_zero, i_clk, i_rst_n, o_m_axis_tvalid && !o_m_axis_tuser[0], o_m_axis_tdata == '0, "invalid result carries a value")

    // a stalled result holds
    `SSI_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser), "stalled result changed")

endmodule

bind sparse_series_interpolator_core ssi_checker u_ssi_checker (.*);

FILE: verif/ssi_checker.sv
// ---------------------------------------------------------------------------
// sparse series interpolator checker
// watches the item, result and register channels, predicts every query
// answer from its own copy of table and registers, and compares in order
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ssi_scoreboard (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_valid,
    input  logic                           i_s_ready,
    input  logic [ssi_pkg::S_TDATA_W-1:0]  i_s_data,
    input  logic [0:0]                     i_s_user,
    input  logic                           i_m_valid,
    input  logic                           i_m_ready,
    input  logic [ssi_pkg::M_TDATA_W-1:0]  i_m_data,
    input  logic [0:0]                     i_m_user,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [ssi_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ssi_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                             o_errors,
    output int                             o_pending
);
    import ssi_pkg::*;

    typedef struct packed {
        logic [31:0] value;
        logic        valid;
    } t_answer;

    t_answer awaited_answers[$];

    // shadow table and registers
    logic signed [63:0] bp_time [DEF_MAX_POINTS];
    logic signed [63:0] bp_value[DEF_MAX_POINTS];
    logic [1:0]         interp_mode;
    logic [1:0]         extrap_mode;
    logic [6:0]         point_count;
    logic signed [63:0] ser_start;
    logic signed [63:0] ser_end;
    logic signed [63:0] step_len;

    // fraction by restoring division, then truncated scaled delta
    function automatic logic [31:0] segment_mix(input logic signed [63:0] vl,
                                                input logic signed [63:0] vr,
                                                input logic signed [63:0] num,
                                                input logic signed [63:0] den);
        logic [63:0]        rem;
        logic [63:0]        frac;
        logic [63:0]        mag;
        logic [63:0]        prod;
        logic signed [63:0] diff;
        logic signed [63:0] res;
        rem  = num;
        frac = '0;
        for (int k = 0; k < 32; k++) begin
            rem  = rem << 1;
            frac = frac << 1;
            if (rem >= den) begin
                rem     = rem - den;
                frac[0] = 1'b1;
            end
        end
        diff = vr - vl;
        mag  = (diff < 0) ? -diff : diff;
        prod = (mag * frac) >> 32;
        res  = (diff < 0) ? vl - $signed(prod) : vl + $signed(prod);
        return res[31:0];
    endfunction

    // answer for a query time, wrapping periodically where asked
    function automatic t_answer lookup_answer(input logic signed [63:0] qt);
        int                 n;
        int                 left;
        int                 wraps;
        logic signed [63:0] t;
        logic signed [63:0] period;
        t_answer            none;
        none   = '0;
        n      = (point_count > DEF_MAX_POINTS) ? DEF_MAX_POINTS : point_count;
        period = ser_end - ser_start + step_len;
        t      = qt;
        wraps  = 0;
        if (n == 0) return none;
        while (1) begin
            left = -1;
            for (int i = 0; i < n; i++) begin
                if (t >= bp_time[i]) left = i;
            end
            // before the first entry
            if (left < 0) begin
                if (extrap_mode == MODE_HOLD) return '{bp_value[0][31:0], 1'b1};
                if (extrap_mode != MODE_PERIODIC || wraps >= DEF_MAX_WRAPS) return none;
                wraps++;
                t = t + period;
                continue;
            end
            // inside the table
            if (left < n - 1) begin
                if (interp_mode == MODE_HOLD) return '{bp_value[left][31:0], 1'b1};
                if (interp_mode == MODE_LINEAR)
                    return '{segment_mix(bp_value[left], bp_value[left+1],
                                         t - bp_time[left],
                                         bp_time[left+1] - bp_time[left]), 1'b1};
                return none;
            end
            // at or past the last entry
            if (extrap_mode == MODE_HOLD) return '{bp_value[n-1][31:0], 1'b1};
            if (extrap_mode != MODE_PERIODIC) return none;
            if (t >= ser_end + step_len) begin
                if (wraps >= DEF_MAX_WRAPS) return none;
                wraps++;
                t = t - period;
                continue;
            end
            if (interp_mode == MODE_HOLD) return '{bp_value[n-1][31:0], 1'b1};
            if (interp_mode == MODE_LINEAR)
                return '{segment_mix(bp_value[n-1], bp_value[0], t - bp_time[n-1],
                                     ser_end + step_len - bp_time[n-1]), 1'b1};
            return none;
        end
        return none;
    endfunction

    // monitor all three channels
    always @(posedge i_clk) begin
        t_answer want;
        t_answer got;
        if (!i_rst_n) begin
            interp_mode = MODE_LINEAR;
            extrap_mode = MODE_HOLD;
            point_count = '0;
            ser_start   = 0;
            ser_end     = 0;
            step_len    = 1;
            awaited_answers.delete();
            o_errors   <= 0;
            o_pending  <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_INTERP: interp_mode = i_cfg_data[1:0];
                    REG_EXTRAP: extrap_mode = i_cfg_data[1:0];
                    REG_COUNT:  point_count = i_cfg_data[6:0];
                    REG_START:  ser_start   = sext_time(i_cfg_data);
                    REG_END:    ser_end     = sext_time(i_cfg_data);
                    REG_STEP:   step_len    = {17'd0, i_cfg_data[46:0]};
                    default: ;
                endcase
            end
            if (i_s_valid && i_s_ready) begin
                if (i_s_user[0] == FUNC_LOAD) begin
                    bp_time[i_s_data[5:0]]  = sext_time(i_s_data[53:6]);
                    bp_value[i_s_data[5:0]] = {{32{i_s_data[85]}}, i_s_data[85:54]};
                end else begin
                    awaited_answers = {awaited_answers,
                                       lookup_answer(sext_time(i_s_data[133:86]))};
                end
            end
            if (i_m_valid && i_m_ready) begin
                got = '{i_m_data, i_m_user[0]};
                if (awaited_answers.size() == 0) begin
                    o_errors <= o_errors + 1;
                    $display("%0t unexpected result: actual value %h valid %0d",
                             $time, got.value, got.valid);
                end else begin
                    want = awaited_answers.pop_front();
                    if (want !== got) begin
                        o_errors <= o_errors + 1;
                        $display("%0t mismatch: expected value %h valid %0d, actual value %h valid %0d",
                                 $time, want.value, want.valid, got.value, got.valid);
                    end
                end
            end
            o_pending <= awaited_answers.size();
        end
    end

endmodule

FILE: verif/testbench.sv
// ---------------------------------------------------------------------------
// sparse series interpolator testbench
// loads breakpoint tables, sweeps the lookup modes and queries inside,
// outside and far beyond the table with random idling on both sides
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import ssi_pkg::*;

    localparam logic [1:0] MODE_SPARE = 2'd3;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [S_TDATA_W-1:0]  s_data = '0;
    logic [0:0]            s_user = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [M_TDATA_W-1:0]  m_data;
    logic [0:0]            m_user;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    int                    errors;
    int                    pending;
    int                    items_sent = 0;
    bit                    hold_req = 1'b0;
    logic signed [63:0]    tab_first;
    logic signed [63:0]    tab_last;

    always #5 clk = ~clk;

    sparse_series_interpolator_core dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_s_axis_tvalid(s_valid), .o_s_axis_tready(s_ready),
        .i_s_axis_tdata(s_data), .i_s_axis_tuser(s_user),
        .o_m_axis_tvalid(m_valid), .i_m_axis_tready(m_ready),
        .o_m_axis_tdata(m_data), .o_m_axis_tuser(m_user),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    ssi_scoreboard u_scoreboard (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_s_valid(s_valid), .i_s_ready(s_ready), .i_s_data(s_data), .i_s_user(s_user),
        .i_m_valid(m_valid), .i_m_ready(m_ready), .i_m_data(m_data), .i_m_user(m_user),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // result side: random stalls plus one long hold-off on request
    always @(posedge clk) begin
        static int stall_left = 0;
        if (hold_req) begin
            stall_left = 600;
            hold_req   = 1'b0;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            stall_left = pick_gap();
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic push_item(input logic func, input logic [5:0] idx,
                             input logic [47:0] pt, input logic [31:0] pv,
                             input logic [47:0] qt);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_valid <= 1'b1;
        s_user  <= func;
        s_data  <= {2'b00, qt, pv, pt, idx};
        do @(posedge clk); while (!s_ready);
        items_sent++;
    endtask

    task automatic load_point(input logic [5:0] idx, input logic [47:0] pt,
                              input logic [31:0] pv);
        push_item(FUNC_LOAD, idx, pt, pv, 48'($urandom));
    endtask

    task automatic ask(input logic [47:0] qt);
        push_item(FUNC_QUERY, 6'($urandom), 48'({$urandom, $urandom}), $urandom, qt);
    endtask

    // drain all answers, then let trailing loads finish
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (50) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [47:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic set_regs(input logic [1:0] im, input logic [1:0] em, input int cnt,
                            input logic signed [63:0] st, input logic signed [63:0] en,
                            input logic [46:0] sp);
        settle();
        write_reg(REG_INTERP, 48'(im));
        write_reg(REG_EXTRAP, 48'(em));
        write_reg(REG_COUNT, 48'(cnt));
        write_reg(REG_START, st[47:0]);
        write_reg(REG_END, en[47:0]);
        write_reg(REG_STEP, {1'b0, sp});
        cfg_valid <= 1'b0;
    endtask

    // non-decreasing table in entries 0 .. n-1
    task automatic build_table(input int cnt, input logic signed [63:0] base);
        int                 n;
        int                 r;
        logic signed [63:0] t;
        n = (cnt > DEF_MAX_POINTS) ? DEF_MAX_POINTS : cnt;
        t = base;
        tab_first = base;
        for (int i = 0; i < n; i++) begin
            load_point(6'(i), t[47:0], $urandom);
            tab_last = t;
            r = $urandom_range(0, 19);
            t = t + ((r == 0) ? 0 : (r == 1) ? 1 : $urandom_range(2, 1000));
        end
    endtask

    initial begin
        #50_000_000;
        $display("testbench: FAIL");
        $finish;
    end

    initial begin
        int                 cnt;
        int                 phase;
        int                 r;
        int                 span;
        logic [1:0]         im;
        logic [1:0]         em;
        logic signed [63:0] st;
        logic signed [63:0] en;
        logic [46:0]        sp;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table
        ask(48'd0);
        // small table with extreme values
        load_point(6'd0, 48'd0, 32'h8000_0000);
        load_point(6'd1, 48'd100, 32'h7FFF_FFFF);
        load_point(6'd2, 48'd200, 32'h0000_0000);
        load_point(6'd3, 48'd300, 32'hFFFF_FFFF);
        set_regs(MODE_LINEAR, MODE_HOLD, 4, 0, 300, 47'd100);
        ask(-48'sd50); ask(48'd0); ask(48'd50); ask(48'd150); ask(48'd250);
        ask(48'd300); ask(48'd400); ask(48'h7FFF_FFFF_FFFF); ask(48'h8000_0000_0000);
        // periodic wrap both ways, wrap limit on far times
        set_regs(MODE_LINEAR, MODE_PERIODIC, 4, 0, 300, 47'd100);
        ask(-48'sd50); ask(48'd350); ask(48'd1000); ask(48'h7FFF_FFFF_FFFF); ask(-48'sd900);
        // negative period
        set_regs(MODE_HOLD, MODE_PERIODIC, 4, 10, 9, 47'd0);
        ask(-48'sd5); ask(48'd350);
        // modes without meaning
        set_regs(MODE_PERIODIC, MODE_LINEAR, 4, 0, 300, 47'd100);
        ask(48'd50); ask(48'd500);
        set_regs(MODE_SPARE, MODE_SPARE, 4, 0, 300, 47'h7FFF_FFFF_FFFF);
        ask(48'd50); ask(-48'sd500);

        // random phases
        phase = 0;
        while (items_sent < 760) begin
            r = $urandom_range(0, 99);
            cnt = (r < 8) ? $urandom_range(64, 127) : (r < 18) ? 1 : $urandom_range(2, 8);
            build_table(cnt, $signed(64'($urandom_range(0, 2097152))) - 64'sd1048576);
            r  = $urandom_range(0, 99);
            im = (r < 45) ? MODE_LINEAR : (r < 80) ? MODE_HOLD : 2'($urandom_range(2, 3));
            r  = $urandom_range(0, 99);
            em = (r < 50) ? MODE_PERIODIC : (r < 85) ? MODE_HOLD
                                          : (r < 93) ? MODE_LINEAR : MODE_SPARE;
            st = ($urandom_range(0, 4) != 0) ? tab_first
                                             : $signed(48'({$urandom, $urandom}));
            en = ($urandom_range(0, 4) != 0) ? tab_last
                                             : $signed(48'({$urandom, $urandom}));
            r  = $urandom_range(0, 9);
            sp = (r < 8) ? 47'($urandom_range(1, 1000)) : (r == 8) ? 47'd0
               : ($urandom_range(0, 1) ? 47'h7FFF_FFFF_FFFF : 47'({$urandom, $urandom}));
            set_regs(im, em, cnt, st, en, sp);
            if (phase == 3) hold_req = 1'b1;
            span = int'(tab_last - tab_first) + 200;
            repeat ($urandom_range(20, 60)) begin
                r = $urandom_range(0, 99);
                if (r < 12)
                    load_point(6'($urandom), 48'({$urandom, $urandom}), $urandom);
                else if (r < 20)
                    ask(48'({$urandom, $urandom}));
                else
                    ask(48'(tab_first + $urandom_range(0, 6 * span) - 2 * span));
            end
            phase++;
        end

        settle();
        if (errors == 0 && pending == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
